/* hw/rtl/scfp_pkg.sv */
// Shared types and constants for the serial command frame parser.
// No dependencies; imported by scfp_front, scfp_back and the top level.

package scfp_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR0      = 8'h0A;
  localparam logic [7:0] HDR1      = 8'hA0;
  localparam logic [7:0] TAIL_BYTE = 8'h16;

  // Hard payload ceiling and saturation value for reported lengths
  localparam logic [10:0] MAX_PAYLOAD = 11'd1024;
  localparam logic [10:0] LEN_SAT     = 11'h7FF;

  // Register reset values
  localparam logic [7:0]  MAX_CMD_RST = 8'd40;
  localparam logic [10:0] MAX_LEN_RST = 11'd1024;

  // Depth of the classified-byte queue between front and back
  localparam int Q_DEPTH = 4;

  // Register indexes (byte address bit 2)
  localparam logic REG_MAX_COMMAND = 1'b0;
  localparam logic REG_MAX_LENGTH  = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LENHI,
    PH_LENLO,
    PH_DATA,
    PH_SUM,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_REJECT  = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COMMAND  = 3'd1,
    ERR_LENGTH   = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_TAIL     = 3'd4
  } err_t;

  // One received byte with its precomputed class flags
  typedef struct packed {
    logic [7:0] data;
    logic       hdr0;
    logic       hdr1;
    logic       tail;
    logic       cmd_bad;
  } item_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  cmd;
    logic [10:0] len;
    logic [7:0]  pbyte;
    logic [9:0]  idx;
    err_t        err;
  } result_t;

endpackage

/* hw/rtl/scfp_front.sv */
// Front end: accepts received bytes, classifies them and queues them.
// Depends on scfp_pkg (item_t, delimiters, Q_DEPTH).

module scfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_command,
  output logic              item_valid,
  output scfp_pkg::item_t   item,
  input  logic              item_pop
);
  import scfp_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t             q_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  item_t             cls;
  logic              push;

  always_comb begin
    cls.data    = rx_byte;
    cls.hdr0    = (rx_byte == HDR0);
    cls.hdr1    = (rx_byte == HDR1);
    cls.tail    = (rx_byte == TAIL_BYTE);
    cls.cmd_bad = (rx_byte > max_command);
  end

  assign in_tready  = (count_r != CNT_W'(Q_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign item_valid = (count_r != '0);
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (item_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !item_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && item_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid)
    else $error("queue popped while empty");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !item_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

  a_queued_class: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid |-> (item.hdr0 == (item.data == HDR0)) &&
                   (item.tail == (item.data == TAIL_BYTE)))
    else $error("queued byte class flags inconsistent");

endmodule

/* hw/rtl/scfp_back.sv */
// Back end: frame state machine with checksum, length check and result register.
// Depends on scfp_pkg (phase_t, event_t, err_t, item_t, result_t).

module scfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  scfp_pkg::item_t    item,
  output logic               item_pop,
  input  logic [10:0]        max_length,
  output logic               out_valid,
  input  logic               out_ready,
  output scfp_pkg::result_t  out_res
);
  import scfp_pkg::*;

  phase_t       phase_r, phase_nxt;
  logic         hfs_r, hfs_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [7:0]   lenhi_r, lenhi_nxt;
  logic [10:0]  len_r, len_nxt;
  logic [10:0]  rem_r, rem_nxt;
  logic [9:0]   idx_r, idx_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic         out_valid_r, out_valid_nxt;
  result_t      out_res_r, out_res_nxt;

  logic         emit;
  result_t      res;
  logic [10:0]  limit;
  logic [15:0]  full;
  logic         len_bad;
  logic [10:0]  full_sat;
  logic [7:0]   sum_add;
  logic [7:0]   b;

  assign b        = item.data;
  assign item_pop = item_valid && (!out_valid_r || out_ready);
  assign limit    = (max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : max_length;
  assign full     = {lenhi_r, b};
  assign len_bad  = (full > {5'd0, limit});
  assign full_sat = (|full[15:11]) ? LEN_SAT : full[10:0];
  assign sum_add  = sum_r + b;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (item_pop) begin
      case (phase_r)
        PH_CMD:   phase_nxt = item.cmd_bad ? PH_HUNT : PH_LENHI;
        PH_LENHI: phase_nxt = PH_LENLO;
        PH_LENLO: begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = (full == 16'd0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA:  phase_nxt = (rem_r == 11'd1) ? PH_SUM : PH_DATA;
        PH_SUM:   phase_nxt = (b == sum_r) ? PH_TAIL : PH_HUNT;
        PH_TAIL:  phase_nxt = PH_HUNT;
        default:  phase_nxt = (item.hdr1 && hfs_r) ? PH_CMD : PH_HUNT;
      endcase
    end
  end

  // Result and datapath
  always_comb begin
    emit      = 1'b0;
    res.ev    = EV_PAYLOAD;
    res.cmd   = cmd_r;
    res.len   = len_r;
    res.pbyte = '0;
    res.idx   = '0;
    res.err   = ERR_NONE;
    hfs_nxt   = hfs_r;
    cmd_nxt   = cmd_r;
    lenhi_nxt = lenhi_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    if (item_pop) begin
      case (phase_r)
        PH_CMD: begin
          if (item.cmd_bad) begin
            emit    = 1'b1;
            res.ev  = EV_REJECT;
            res.cmd = b;
            res.len = '0;
            res.err = ERR_COMMAND;
            hfs_nxt = item.hdr0;
          end else begin
            cmd_nxt = b;
            sum_nxt = b;
          end
        end
        PH_LENHI: begin
          lenhi_nxt = b;
          sum_nxt   = sum_add;
        end
        PH_LENLO: begin
          if (len_bad) begin
            emit    = 1'b1;
            res.ev  = EV_REJECT;
            res.len = full_sat;
            res.err = ERR_LENGTH;
            hfs_nxt = item.hdr0;
          end else begin
            sum_nxt = sum_add;
            len_nxt = full[10:0];
            rem_nxt = full[10:0];
            idx_nxt = '0;
          end
        end
        PH_DATA: begin
          emit      = 1'b1;
          res.pbyte = b;
          res.idx   = idx_r;
          sum_nxt   = sum_add;
          rem_nxt   = rem_r - 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end
        PH_SUM: begin
          if (b != sum_r) begin
            emit    = 1'b1;
            res.ev  = EV_REJECT;
            res.err = ERR_CHECKSUM;
            hfs_nxt = item.hdr0;
          end
        end
        PH_TAIL: begin
          emit = 1'b1;
          if (item.tail) begin
            res.ev  = EV_ACCEPT;
            hfs_nxt = 1'b0;
          end else begin
            res.ev  = EV_REJECT;
            res.err = ERR_TAIL;
            hfs_nxt = item.hdr0;
          end
        end
        default: begin
          // 0x0A arms, anything else (including the 0xA0 that starts a frame) disarms
          hfs_nxt = item.hdr0;
        end
      endcase
    end
  end

  // Output register: loads a new result when it is empty or while the previous one is taken
  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (item_pop && emit) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hfs_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hfs_r       <= hfs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    lenhi_r   <= lenhi_nxt;
    len_r     <= len_nxt;
    rem_r     <= rem_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (rem_r != 11'd0))
    else $error("payload phase with nothing remaining");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && phase_r == PH_DATA && rem_r == 11'd1) |=> (phase_r == PH_SUM))
    else $error("last payload byte did not lead to checksum");

  a_payload_out: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && phase_r == PH_DATA) |=> (out_valid && out_res.ev == EV_PAYLOAD))
    else $error("payload byte produced no result");

  a_tail_out: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && phase_r == PH_TAIL) |=>
      (out_valid && phase_r == PH_HUNT &&
       (out_res.ev == EV_ACCEPT || out_res.ev == EV_REJECT)))
    else $error("tail byte did not close the frame");

endmodule

/* hw/rtl/serial_command_frame_parser.sv */
// Serial command frame parser: received bytes in, payload/accept/reject
// transactions out. Frame: 0A A0, command, length hi, length lo, payload,
// 8-bit additive checksum, 16 tail.
// Input channel: one byte per transaction in in_tdata[7:0].
// Output channel: one transaction per payload byte and one at frame end
// (accept or reject with an error code); header, command, length and
// checksum bytes of a good frame produce no transaction.
// A received byte passes through the queue and then the output register.
// Throughput: one byte per cycle; the back end takes one byte from the
// four-entry queue per cycle, limited only by the output register.
// If the receiver stalls, the output register holds, the back end stops and
// the queue fills; in_tready drops when four bytes wait.
// Reset (synchronous, active low) empties the queue and output register,
// sets the parser to header hunt, max_command to 40 and max_length to 1024.
// Registers: 0x0 max_command, 0x4 max_length; write only while idle.
// Depends on scfp_pkg, scfp_front, scfp_back.

module serial_command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] command, [18:8] frame_length,
                                    // [26:19] payload_byte, [36:27] payload_index,
                                    // [39:37] error_code
  output logic [1:0]  out_tuser,    // [1:0] event_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import scfp_pkg::*;

  logic [7:0]  max_cmd_r, max_cmd_nxt;
  logic [10:0] max_len_r, max_len_nxt;
  logic        cfg_wr;
  logic        item_valid;
  item_t       item;
  logic        item_pop;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    max_cmd_nxt = max_cmd_r;
    max_len_nxt = max_len_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MAX_COMMAND: max_cmd_nxt = cfg_pwdata[7:0];
        REG_MAX_LENGTH:  max_len_nxt = cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MAX_COMMAND: cfg_prdata = {24'd0, max_cmd_r};
      REG_MAX_LENGTH:  cfg_prdata = {21'd0, max_len_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cmd_r <= MAX_CMD_RST;
      max_len_r <= MAX_LEN_RST;
    end else begin
      max_cmd_r <= max_cmd_nxt;
      max_len_r <= max_len_nxt;
    end
  end

  scfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .rx_byte     (in_tdata),
    .max_command (max_cmd_r),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  scfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .max_length (max_len_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {res.err, res.idx, res.pbyte, res.len, res.cmd};
  assign out_tuser = res.ev;

endmodule
